### rtl/core/hesr_pkg.sv
// Shared types and constants for the 1D explicit heat-equation stencil solver.
// No dependencies; used by hesr_ctrl, hesr_cell and heat_explicit_stencil_run_top.
`default_nettype none

package hesr_pkg;

    localparam int MAX_POINTS_DEF = 64;

    localparam int ALPHA_W = 17;
    localparam int N_W     = 6;
    localparam int STEP_W  = 16;
    localparam int VAL_W   = 32;
    localparam int CFG_W   = 17;

    localparam logic [ALPHA_W-1:0] ALPHA_RST = 17'd16384;
    localparam logic [N_W-1:0]     N_RST     = 6'd32;

    // one in Q4.28
    localparam logic signed [VAL_W-1:0] ONE_Q28 = 32'sh1000_0000;

    // register indexes on the config port
    localparam logic CFG_ALPHA = 1'b0;
    localparam logic CFG_N     = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_EMIT = 3'b100
    } t_state;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic               load;   // clear grid for a new run
        logic               step;   // apply one time step
        logic               shift;  // move values one cell toward index 0
        logic [N_W-1:0]     n;      // effective interval count
        logic [ALPHA_W-1:0] alpha;
    } t_cell_ctl;

endpackage

`default_nettype wire

### rtl/core/heat_explicit_stencil_run_top.sv
// Top level of the 1D explicit (FTCS) heat-equation solver: controller plus a
// chain of MAX_POINTS stencil cells. Uses hesr_pkg, hesr_ctrl, hesr_cell.
// Sequence: the grid is cleared when a run is accepted, then step_count time steps
// (one time step per cycle, all cells updating in parallel), then n+1 output beats
// shifted out of cell 0. A new run is taken only after the last beat of the
// previous one.
// Reset (synchronous, active low): idle, alpha = 0.25, n = 32.
`default_nettype none

module heat_explicit_stencil_run_top #(
    parameter int MAX_POINTS = hesr_pkg::MAX_POINTS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire         i_cfg_idx,
    input  wire  [16:0] i_cfg_data,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [15:0] s_axis_tdata,   // [15:0] step_count
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [5:0] point_index, [37:6] temperature, zero pad
    output logic        m_axis_tlast    // last_point
);

    hesr_pkg::t_cell_ctl w_ctl;
    logic [hesr_pkg::N_W-1:0] w_point_index;
    logic signed [hesr_pkg::VAL_W-1:0] w_val [MAX_POINTS];

    hesr_ctrl #(
        .MAX_POINTS(MAX_POINTS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (s_axis_tvalid),
        .i_step_count (s_axis_tdata),
        .o_in_ready   (s_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out_last   (m_axis_tlast),
        .o_point_index(w_point_index),
        .o_ctl        (w_ctl)
    );

    for (genvar g = 0; g < MAX_POINTS; g++) begin : g_cell
        logic signed [hesr_pkg::VAL_W-1:0] w_left, w_right;
        if (g == 0) begin : g_l0
            assign w_left = '0;
        end else begin : g_ln
            assign w_left = w_val[g-1];
        end
        if (g == MAX_POINTS - 1) begin : g_r0
            assign w_right = '0;
        end else begin : g_rn
            assign w_right = w_val[g+1];
        end
        hesr_cell #(
            .IDX(g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_ctl  (w_ctl),
            .i_left (w_left),
            .i_right(w_right),
            .o_value(w_val[g])
        );
    end

    assign m_axis_tdata = {2'b00, w_val[0], w_point_index};

endmodule

`default_nettype wire

### rtl/core/hesr_cell.sv
// One grid point of the stencil chain: holds its value, updates from its
// neighbors each time step and shifts toward index 0 during output. Uses hesr_pkg.
`default_nettype none

module hesr_cell #(
    parameter int IDX = 0
) (
    input  wire                               i_clk,
    input  wire hesr_pkg::t_cell_ctl          i_ctl,
    input  wire logic signed [hesr_pkg::VAL_W-1:0] i_left,
    input  wire logic signed [hesr_pkg::VAL_W-1:0] i_right,
    output logic signed [hesr_pkg::VAL_W-1:0] o_value
);

    localparam logic [hesr_pkg::N_W-1:0] MY_IDX = hesr_pkg::N_W'(IDX);

    logic signed [hesr_pkg::VAL_W-1:0] r_value;
    logic signed [hesr_pkg::VAL_W-1:0] n_value;

    // a*l + (1-2a)*c + a*r  ==  c*2^16 + a*(l + r - 2c)
    logic signed [33:0] w_diff;
    logic signed [51:0] w_prod;
    logic signed [51:0] w_rnd;
    logic signed [35:0] w_delta;
    logic signed [36:0] w_sum;
    logic signed [hesr_pkg::VAL_W-1:0] w_upd;
    logic              w_interior;

    assign w_interior = (MY_IDX != '0) && (MY_IDX < i_ctl.n);

    always_comb begin
        w_diff  = 34'(i_left) + 34'(i_right) - (34'(r_value) <<< 1);
        w_prod  = $signed({1'b0, i_ctl.alpha}) * w_diff;
        w_rnd   = w_prod + 52'sd32768;
        w_delta = 36'(w_rnd >>> 16);  // floor, round half up overall
        w_sum   = 37'(r_value) + 37'(w_delta);
        if (w_sum > 37'sd2147483647) begin
            w_upd = 32'sh7FFF_FFFF;
        end else if (w_sum < -37'sd2147483648) begin
            w_upd = 32'sh8000_0000;
        end else begin
            w_upd = w_sum[hesr_pkg::VAL_W-1:0];
        end
    end

    always_comb begin
        n_value = r_value;
        if (i_ctl.load) begin
            n_value = (MY_IDX == i_ctl.n) ? hesr_pkg::ONE_Q28 : '0;
        end else if (i_ctl.step) begin
            if (w_interior) begin
                n_value = w_upd;
            end
        end else if (i_ctl.shift) begin
            n_value = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

`default_nettype wire

### rtl/core/hesr_ctrl.sv
// Run sequencer for the stencil chain: config registers, step counter and
// output beat counter; drives the cell control struct. Uses hesr_pkg.
`default_nettype none

module hesr_ctrl #(
    parameter int MAX_POINTS = hesr_pkg::MAX_POINTS_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire                              i_cfg_idx,
    input  wire [hesr_pkg::CFG_W-1:0]        i_cfg_data,
    input  wire                              i_in_valid,
    input  wire [hesr_pkg::STEP_W-1:0]       i_step_count,
    output logic                             o_in_ready,
    output logic                             o_out_valid,
    input  wire                              i_out_ready,
    output logic                             o_out_last,
    output logic [hesr_pkg::N_W-1:0]         o_point_index,
    output hesr_pkg::t_cell_ctl              o_ctl
);

    localparam logic [hesr_pkg::N_W-1:0] N_MAX = hesr_pkg::N_W'(MAX_POINTS - 1);

    hesr_pkg::t_state r_state, n_state;
    logic [hesr_pkg::ALPHA_W-1:0] r_alpha;
    logic [hesr_pkg::N_W-1:0]     r_grid_n;
    logic [hesr_pkg::N_W-1:0]     r_n, n_n;
    logic [hesr_pkg::STEP_W-1:0]  r_steps, n_steps;
    logic [hesr_pkg::N_W-1:0]     r_idx, n_idx;
    logic [hesr_pkg::N_W-1:0]     w_eff_n;
    logic                         w_in_acc, w_out_acc;

    always_comb begin
        w_eff_n = r_grid_n;
        if (r_grid_n == '0) begin
            w_eff_n = hesr_pkg::N_W'(1);
        end else if (r_grid_n > N_MAX) begin
            w_eff_n = N_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha  <= hesr_pkg::ALPHA_RST;
            r_grid_n <= hesr_pkg::N_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                hesr_pkg::CFG_ALPHA: r_alpha  <= i_cfg_data;
                hesr_pkg::CFG_N:     r_grid_n <= i_cfg_data[hesr_pkg::N_W-1:0];
            endcase
        end
    end

    assign o_in_ready  = (r_state == hesr_pkg::ST_IDLE);
    assign o_out_valid = (r_state == hesr_pkg::ST_EMIT);
    assign o_out_last  = o_out_valid && (r_idx == r_n);
    assign o_point_index = r_idx;
    assign w_in_acc  = i_in_valid && o_in_ready;
    assign w_out_acc = o_out_valid && i_out_ready;

    always_comb begin
        n_state = r_state;
        n_n     = r_n;
        n_steps = r_steps;
        n_idx   = r_idx;
        o_ctl.load  = 1'b0;
        o_ctl.step  = 1'b0;
        o_ctl.shift = 1'b0;
        o_ctl.n     = r_n;
        o_ctl.alpha = r_alpha;
        unique case (r_state)
            hesr_pkg::ST_IDLE: begin
                o_ctl.n = w_eff_n;
                if (w_in_acc) begin
                    o_ctl.load = 1'b1;
                    n_n     = w_eff_n;
                    n_steps = i_step_count;
                    n_idx   = '0;
                    n_state = (i_step_count == '0) ? hesr_pkg::ST_EMIT : hesr_pkg::ST_RUN;
                end
            end
            hesr_pkg::ST_RUN: begin
                o_ctl.step = 1'b1;
                n_steps    = r_steps - 1'b1;
                if (r_steps == hesr_pkg::STEP_W'(1)) begin
                    n_state = hesr_pkg::ST_EMIT;
                end
            end
            hesr_pkg::ST_EMIT: begin
                if (w_out_acc) begin
                    o_ctl.shift = 1'b1;
                    n_idx       = r_idx + 1'b1;
                    if (r_idx == r_n) begin
                        n_state = hesr_pkg::ST_IDLE;
                    end
                end
            end
            default: n_state = hesr_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hesr_pkg::ST_IDLE;
            r_idx   <= '0;
            r_steps <= '0;
            r_n     <= hesr_pkg::N_W'(1);
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_steps <= n_steps;
            r_n     <= n_n;
        end
    end

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input accepted while results pending");

    a_run_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_step_count != '0)) |=> (r_state == hesr_pkg::ST_RUN))
        else $error("run did not start stepping");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && o_out_last) |=> o_in_ready)
        else $error("not idle after last beat");

    a_idx_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && !o_out_last) |=> (r_idx == $past(r_idx) + 1'b1))
        else $error("point index did not advance");

endmodule

`default_nettype wire

### bench/heat_explicit_stencil_run_top_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for heat_explicit_stencil_run_top: sends step-count runs
// under several alpha / interval settings and checks every emitted grid point.
// Depends on hesr_pkg and the top-level RTL only.

module heat_explicit_stencil_run_top_tb;

    typedef struct {
        logic [hesr_pkg::N_W-1:0]          idx;
        logic signed [hesr_pkg::VAL_W-1:0] temp;
        logic                              last;
    } t_grid_point;

    class heat_grid_checker;
        logic [hesr_pkg::ALPHA_W-1:0] alpha;
        logic [hesr_pkg::N_W-1:0]     intervals;
        t_grid_point                  expected_points[$];
        int                           mismatches;

        function new();
            alpha      = hesr_pkg::ALPHA_RST;
            intervals  = hesr_pkg::N_RST;
            mismatches = 0;
        endfunction

        function void set_reg(logic idx, logic [hesr_pkg::CFG_W-1:0] data);
            if (idx == hesr_pkg::CFG_ALPHA) begin
                alpha = data[hesr_pkg::ALPHA_W-1:0];
            end else if (idx == hesr_pkg::CFG_N) begin
                intervals = data[hesr_pkg::N_W-1:0];
            end
        endfunction

        // Runs the FTCS stencil for one accepted run and queues its n+1 points.
        function void note_run(logic [hesr_pkg::STEP_W-1:0] steps);
            logic signed [hesr_pkg::VAL_W-1:0] grid [hesr_pkg::MAX_POINTS_DEF];
            logic signed [hesr_pkg::VAL_W-1:0] nxt [hesr_pkg::MAX_POINTS_DEF];
            longint                            a, c, side, acc, q;
            int                                n;
            bit                                moved;
            t_grid_point                       pt;
            n = (intervals == 0) ? 1 : int'(intervals);
            a = longint'(alpha);
            c = 65536 - 2 * a;
            foreach (grid[i]) grid[i] = '0;
            grid[n] = hesr_pkg::ONE_Q28;
            for (int t = 0; t < int'(steps); t++) begin
                moved = 1'b0;
                nxt = grid;
                for (int i = 1; i < n; i++) begin
                    side = longint'(grid[i-1]) + longint'(grid[i+1]);
                    acc  = a * side + c * longint'(grid[i]) + 32768;
                    q    = acc >>> 16;
                    if (q > longint'(32'sh7FFF_FFFF)) begin
                        nxt[i] = 32'sh7FFF_FFFF;
                    end else if (q < longint'(32'sh8000_0000)) begin
                        nxt[i] = 32'sh8000_0000;
                    end else begin
                        nxt[i] = q[hesr_pkg::VAL_W-1:0];
                    end
                    if (nxt[i] != grid[i]) moved = 1'b1;
                end
                grid = nxt;
                // fixed point reached: further steps change nothing
                if (!moved) break;
            end
            for (int i = 0; i <= n; i++) begin
                pt.idx  = i[hesr_pkg::N_W-1:0];
                pt.temp = grid[i];
                pt.last = (i == n);
                expected_points.push_back(pt);
            end
        endfunction

        function void check_point(logic [hesr_pkg::N_W-1:0] idx,
                                  logic signed [hesr_pkg::VAL_W-1:0] temp,
                                  logic last);
            t_grid_point want;
            if (expected_points.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: idx %0d temp %h last %b", idx, temp, last);
                return;
            end
            want = expected_points.pop_front();
            if (idx !== want.idx || temp !== want.temp || last !== want.last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"point mismatch: expected idx %0d temp %h last %b, ",
                              "got idx %0d temp %h last %b"},
                             want.idx, want.temp, want.last, idx, temp, last);
            end
        endfunction
    endclass

    logic                         i_clk;
    logic                         i_rst_n       = 1'b0;
    logic                         i_cfg_we      = 1'b0;
    logic                         i_cfg_idx     = hesr_pkg::CFG_ALPHA;
    logic [hesr_pkg::CFG_W-1:0]   i_cfg_data    = '0;
    logic                         s_axis_tvalid = 1'b0;
    logic                         s_axis_tready;
    logic [15:0]                  s_axis_tdata  = '0;   // [15:0] step_count
    logic                         m_axis_tvalid;
    logic                         m_axis_tready = 1'b0;
    logic [39:0]                  m_axis_tdata;  // [5:0] point_index, [37:6] temperature
    logic                         m_axis_tlast;  // last_point

    heat_grid_checker board = new();
    bit               jitter_on = 1'b1;
    int               sink_hold = 0;

    heat_explicit_stencil_run_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $display("heat_explicit_stencil_run_top_tb: FAIL");
        $finish;
    end

    // result side: check each beat, then pick next tready
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready)
                board.check_point(m_axis_tdata[5:0], m_axis_tdata[37:6], m_axis_tlast);
            if (sink_hold > 0) begin
                sink_hold--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= !(jitter_on && $urandom_range(99) < 14);
            end
        end
    end

    task automatic write_reg(logic idx, logic [hesr_pkg::CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        board.set_reg(idx, data);
        i_cfg_we   <= 1'b0;
    endtask

    // valid stays high across back-to-back beats; it is lowered only for a gap or while draining
    task automatic send_run(logic [hesr_pkg::STEP_W-1:0] steps);
        if (jitter_on && $urandom_range(99) < 14) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 14);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= steps;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        board.note_run(steps);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (board.expected_points.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    initial begin
        logic [hesr_pkg::ALPHA_W-1:0] alpha_pick;
        logic [hesr_pkg::N_W-1:0]     n_pick;
        logic [hesr_pkg::STEP_W-1:0]  steps;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: empty run, single steps, longest run
        send_run(16'd0);
        send_run(16'd1);
        send_run(16'd2);
        send_run(16'hFFFF);
        wait_drained();
        // no diffusion on the widest grid
        write_reg(hesr_pkg::CFG_ALPHA, 17'd0);
        write_reg(hesr_pkg::CFG_N, 17'd63);
        send_run(16'd1);
        send_run(16'd5);
        wait_drained();
        // zero intervals acts as one, largest alpha
        write_reg(hesr_pkg::CFG_ALPHA, 17'h1FFFF);
        write_reg(hesr_pkg::CFG_N, 17'd0);
        send_run(16'd0);
        send_run(16'd3);
        wait_drained();
        // alpha one half: centre weight zero
        write_reg(hesr_pkg::CFG_ALPHA, 17'd32768);
        write_reg(hesr_pkg::CFG_N, 17'd2);
        send_run(16'd1);
        send_run(16'd4);
        wait_drained();
        // unstable alpha, values blow up and saturate
        write_reg(hesr_pkg::CFG_ALPHA, 17'h1FFFF);
        write_reg(hesr_pkg::CFG_N, 17'd63);
        send_run(16'd1);
        send_run(16'd40);
        wait_drained();
        write_reg(hesr_pkg::CFG_ALPHA, 17'd40000);
        write_reg(hesr_pkg::CFG_N, 17'd6);
        send_run(16'd100);
        wait_drained();
        write_reg(hesr_pkg::CFG_ALPHA, 17'd16384);
        write_reg(hesr_pkg::CFG_N, 17'd1);
        send_run(16'd10);

        for (int ph = 0; ph < 6; ph++) begin
            wait_drained();
            if ($urandom_range(3) == 0)
                alpha_pick = hesr_pkg::ALPHA_W'($urandom_range(131071));
            else
                alpha_pick = hesr_pkg::ALPHA_W'($urandom_range(32768));
            case ($urandom_range(5))
                0:       n_pick = 6'd0;
                1:       n_pick = 6'd63;
                default: n_pick = hesr_pkg::N_W'($urandom_range(63, 1));
            endcase
            write_reg(hesr_pkg::CFG_ALPHA, alpha_pick);
            write_reg(hesr_pkg::CFG_N, {11'd0, n_pick});
            jitter_on = (ph != 2);
            for (int k = 0; k < 14; k++) begin
                // long sink stall while runs keep coming: input must back up
                if (ph == 3 && k == 2) sink_hold = 600;
                if (ph == 4 && k == 7) wait_drained();
                if ($urandom_range(29) == 0)
                    steps = hesr_pkg::STEP_W'($urandom_range(4095));
                else
                    steps = hesr_pkg::STEP_W'($urandom_range(150));
                send_run(steps);
            end
        end
        wait_drained();

        if (board.mismatches == 0) begin
            $display("heat_explicit_stencil_run_top_tb: PASS");
        end else begin
            $display("heat_explicit_stencil_run_top_tb: FAIL");
        end
        $finish;
    end

endmodule
